/* design/sfck_pkg.sv */
// Shared types, constants and per-level curve functions for the curve key block.
package sfck_pkg;

  localparam int BITS_2D        = 32;
  localparam int BITS_3D        = 21;
  localparam int KEY_W          = 64;
  localparam int COORD_W        = 32;
  localparam int COORD_Z_W      = 21;
  localparam int CFG_IDX_W      = 8;
  localparam int LVL2_PER_STAGE = 4;
  localparam int LVL3_PER_STAGE = 3;
  localparam int N_STAGES       = BITS_2D / LVL2_PER_STAGE;
  localparam int STAGES3        = BITS_3D / LVL3_PER_STAGE;

  localparam logic [CFG_IDX_W-1:0] REG_THREE_D    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND = CFG_IDX_W'(1);

  localparam logic [1:0] ORD_UP      [4] = '{2'd0, 2'd3, 2'd1, 2'd2};
  localparam logic [1:0] ORD_RIGHT   [4] = '{2'd3, 2'd2, 2'd0, 2'd1};
  localparam logic [2:0] UNIT_CURVE3 [8] = '{3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd5};
  // Unit-curve positions after which the traversal direction reverses.
  localparam logic [7:0] ROT_FLIPS = 8'b0101_1010;

  // Signed axis map: bit i of a digit goes to bit axis[i], inverted if neg[i].
  typedef struct packed {
    logic [2:0][1:0] axis;
    logic [2:0]      neg;
  } perm3_t;

  // Payload carried down the pipeline.
  typedef struct packed {
    logic             three;
    logic             kind;
    logic [KEY_W-1:0] work;
    logic [1:0]       orient;
    logic             flip;
    perm3_t           perm;
  } pipe_t;

  function automatic perm3_t perm_identity();
    perm3_t p;
    p.axis[0] = 2'd0;
    p.axis[1] = 2'd1;
    p.axis[2] = 2'd2;
    p.neg     = 3'b000;
    return p;
  endfunction

  // 2D digit reorder for the current orientation.
  function automatic logic [1:0] ord2(logic [1:0] orient, logic [1:0] d);
    logic [1:0] dd;
    dd = orient[1] ? ~d : d;
    return orient[0] ? ORD_RIGHT[dd] : ORD_UP[dd];
  endfunction

  // Rotation applied after each unit-curve position; rows 2 and 5 leave it alone.
  function automatic perm3_t rot_entry(logic [2:0] u);
    perm3_t r;
    r = perm_identity();
    case (u)
      3'd0: begin
        r.axis[0] = 2'd1; r.axis[1] = 2'd2; r.axis[2] = 2'd0; r.neg = 3'b000;
      end
      3'd1: begin
        r.axis[0] = 2'd1; r.axis[1] = 2'd0; r.axis[2] = 2'd2; r.neg = 3'b010;
      end
      3'd3: begin
        r.axis[0] = 2'd2; r.axis[1] = 2'd1; r.axis[2] = 2'd0; r.neg = 3'b001;
      end
      3'd4: begin
        r.axis[0] = 2'd2; r.axis[1] = 2'd1; r.axis[2] = 2'd0; r.neg = 3'b100;
      end
      3'd6: begin
        r.axis[0] = 2'd1; r.axis[1] = 2'd0; r.axis[2] = 2'd2; r.neg = 3'b001;
      end
      3'd7: begin
        r.axis[0] = 2'd1; r.axis[1] = 2'd2; r.axis[2] = 2'd0; r.neg = 3'b101;
      end
      default: r = perm_identity();
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_fix(logic [1:0] a);
    return (a == 2'd3) ? 2'd0 : a;
  endfunction

  function automatic logic [2:0] apply3(perm3_t p, logic [2:0] d);
    logic [2:0] o;
    o = 3'b000;
    for (int i = 0; i < 3; i++) begin
      o[axis_fix(p.axis[i])] = d[i] ^ p.neg[i];
    end
    return o;
  endfunction

  function automatic perm3_t compose3(perm3_t p, perm3_t r);
    perm3_t res;
    logic [1:0] col;
    for (int i = 0; i < 3; i++) begin
      col         = axis_fix(p.axis[i]);
      res.axis[i] = r.axis[col];
      res.neg[i]  = r.neg[col] ^ p.neg[i];
    end
    return res;
  endfunction

endpackage

/* design/sfck_if.sv */
// Valid/ready channel interfaces for points, keys and configuration writes.
interface sfck_point_if;
  import sfck_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_Z_W-1:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface sfck_key_if;
  import sfck_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] curve_key;
  modport source (output valid, curve_key, input ready);
  modport sink   (input valid, curve_key, output ready);
endinterface

interface sfck_cfg_if;
  import sfck_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic                 wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* design/space_filling_curve_key_top.sv */
// Top level of the space-filling curve key block: Morton and Hilbert keys in 2D and 3D.
//
// Usage: a point (coord_x, coord_y, coord_z) is offered on point_i and its key
// comes back on key_o, one key per point, in order. Both are valid/ready
// channels; a request moves when valid and ready are high at a clock edge.
// cfg_i writes the two mode registers: index 0 selects 3D keys, index 1 selects
// the Hilbert curve; only bit 0 of the data is kept and other indexes are
// ignored. The configuration port is always ready. The mode in force when a
// point is accepted travels with that point through the pipeline.
//
// The entry register captures the Morton interleave at the accepting edge, then
// eight registered Hilbert stages follow. Each 2D stage resolves four levels of
// the curve and each 3D stage three levels, which sets the pipeline depth.
// Throughput is one point per cycle while key_o is ready.
//
// Reset clears all valid bits and both mode registers (2D Morton). When the
// receiver holds ready low, stages fill up behind the held key and point_i
// ready drops only once every stage is occupied; bubbles are squeezed out.
module space_filling_curve_key_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  sfck_point_if.sink       point_i,
  sfck_cfg_if.sink         cfg_i,
  sfck_key_if.source       key_o
);
  import sfck_pkg::*;

  logic  three_d_q;
  logic  curve_kind_q;

  // Stage 0 is the entry register; stage N_STAGES is the output register.
  logic  stg_valid [N_STAGES+1];
  logic  stg_ready [N_STAGES+1];
  pipe_t stg_data  [N_STAGES+1];

  logic  entry_valid_q;
  pipe_t entry_data_q;
  pipe_t entry_data_d;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q    <= 1'b0;
      curve_kind_q <= 1'b0;
    end else if (cfg_i.valid) begin
      if (cfg_i.reg_index == REG_THREE_D) begin
        three_d_q <= cfg_i.wdata;
      end
      if (cfg_i.reg_index == REG_CURVE_KIND) begin
        curve_kind_q <= cfg_i.wdata;
      end
    end
  end

  // Morton interleave. In 3D the key lives in the low 63 bits and the Hilbert
  // stages consume it from bit 62 downward.
  always_comb begin
    entry_data_d        = '0;
    entry_data_d.three  = three_d_q;
    entry_data_d.kind   = curve_kind_q;
    entry_data_d.orient = 2'd0;
    entry_data_d.flip   = 1'b0;
    entry_data_d.perm   = perm_identity();
    if (!three_d_q) begin
      for (int i = 0; i < BITS_2D; i++) begin
        entry_data_d.work[2*i]   = point_i.coord_x[i];
        entry_data_d.work[2*i+1] = point_i.coord_y[i];
      end
    end else begin
      for (int i = 0; i < BITS_3D; i++) begin
        entry_data_d.work[3*i]   = point_i.coord_x[i];
        entry_data_d.work[3*i+1] = point_i.coord_y[i];
        entry_data_d.work[3*i+2] = point_i.coord_z[i];
      end
    end
  end

  assign point_i.ready = !entry_valid_q || stg_ready[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= 1'b0;
    end else if (point_i.ready) begin
      entry_valid_q <= point_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (point_i.ready && point_i.valid) begin
      entry_data_q <= entry_data_d;
    end
  end

  assign stg_valid[0] = entry_valid_q;
  assign stg_data[0]  = entry_data_q;

  // Hilbert stages. The 3D curve has seven stages of work; the last stage
  // passes 3D items through untouched.
  for (genvar s = 0; s < N_STAGES; s++) begin : g_stage
    sfck_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .active3_i   ((s < STAGES3) ? 1'b1 : 1'b0),
      .in_valid_i  (stg_valid[s]),
      .in_ready_o  (stg_ready[s]),
      .in_data_i   (stg_data[s]),
      .out_valid_o (stg_valid[s+1]),
      .out_ready_i (stg_ready[s+1]),
      .out_data_o  (stg_data[s+1])
    );
  end

  assign stg_ready[N_STAGES] = key_o.ready;
  assign key_o.valid         = stg_valid[N_STAGES];
  assign key_o.curve_key     = stg_data[N_STAGES].work;

endmodule

/* design/sfck_stage.sv */
// One Hilbert pipeline stage: four 2D levels or three 3D levels per item.
module sfck_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active3_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sfck_pkg::pipe_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sfck_pkg::pipe_t out_data_o
);
  import sfck_pkg::*;

  logic  valid_q;
  pipe_t data_q;
  pipe_t data_d;

  always_comb begin
    logic [1:0] d2;
    logic [1:0] n2;
    logic [2:0] d3;
    logic [2:0] u3;
    d2 = '0;
    n2 = '0;
    d3 = '0;
    u3 = '0;
    data_d = in_data_i;
    if (in_data_i.kind) begin
      if (!in_data_i.three) begin
        for (int k = 0; k < LVL2_PER_STAGE; k++) begin
          d2 = data_d.work[KEY_W-1 -: 2];
          n2 = ord2(data_d.orient, d2);
          data_d.work = {data_d.work[KEY_W-3:0], (data_d.flip ? ~n2 : n2)};
          if (n2 == 2'd0) begin
            data_d.orient = data_d.orient + 2'd1;
            data_d.flip   = ~data_d.flip;
          end else if (n2 == 2'd3) begin
            data_d.orient = data_d.orient - 2'd1;
            data_d.flip   = ~data_d.flip;
          end
        end
      end else if (active3_i) begin
        for (int k = 0; k < LVL3_PER_STAGE; k++) begin
          d3 = data_d.work[3*BITS_3D-1 -: 3];
          u3 = UNIT_CURVE3[apply3(data_d.perm, d3)];
          data_d.work = {1'b0, data_d.work[3*BITS_3D-4:0], (data_d.flip ? ~u3 : u3)};
          data_d.perm = compose3(data_d.perm, rot_entry(u3));
          if (ROT_FLIPS[u3]) begin
            data_d.flip = ~data_d.flip;
          end
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
